### rtl/ols_pkg.sv
// Package for the ordered list store: sequencer state type, command codes
// and status codes. It depends on nothing else.
package ols_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_MOVE,
        ST_PUT,
        ST_FRONT,
        ST_FRONT_WAIT,
        ST_DUMP
    } ols_state_t;

    localparam logic [3:0] CMD_PUSH_BACK      = 4'd0;
    localparam logic [3:0] CMD_PUSH_FRONT     = 4'd1;
    localparam logic [3:0] CMD_POP_FRONT      = 4'd2;
    localparam logic [3:0] CMD_POP_BACK       = 4'd3;
    localparam logic [3:0] CMD_DEL_KEY        = 4'd4;
    localparam logic [3:0] CMD_DEL_POS        = 4'd5;
    localparam logic [3:0] CMD_INS_POS        = 4'd6;
    localparam logic [3:0] CMD_INS_BEFORE_KEY = 4'd7;
    localparam logic [3:0] CMD_DUMP           = 4'd8;

    localparam logic [1:0] STAT_DONE    = 2'd0;
    localparam logic [1:0] STAT_IGNORED = 2'd1;
    localparam logic [1:0] STAT_FULL    = 2'd2;

endpackage

### rtl/ordered_list_store_top.sv
// Top level of the ordered list store: command sequencer and datapath.
// It depends on ols_pkg and instantiates ols_ram.
//
// A command beat is taken at a rising edge where start is high and busy is
// low; cmd, value, key and position are sampled then. Every command except
// dump gives one result: status, the front entry (zero when empty) and the
// entry count, with last set. Dump gives one result per entry, front to back,
// with last on the final one; an empty dump gives one ignored result.
// Each result is shown for exactly one cycle with strobe high; the receiver
// cannot stall it, so no result is ever held back.
// All entries live in one RAM with one write and one registered read port,
// and every walk over the list goes through that port one entry per cycle.
// A key search walks the list from the front and stops at the first match,
// a shift moves the entries one at a time, and for every command but dump
// the front entry is read back through the same port. Pop back is the
// shortest command and insert before a key the longest, wherever the key
// is found. After reset the list is empty and busy is low; the RAM contents
// need no clearing because only slots below the count are ever used.
module ordered_list_store_top
    import ols_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [3:0]  cmd,
    input  logic [31:0] value,
    input  logic [31:0] key,
    input  logic [7:0]  position,
    output logic        strobe,
    output logic [1:0]  status,
    output logic [31:0] item_value,
    output logic [6:0]  entry_count,
    output logic        last
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    ols_state_t state_reg, state_next;

    logic [CW-1:0]    count_reg, count_next;
    logic [WIDTH-1:0] val_reg, val_next;
    logic [WIDTH-1:0] key_reg, key_next;
    logic [1:0]       stat_reg, stat_next;
    logic [AW-1:0]    ptr_reg, ptr_next;
    logic [CW-1:0]    left_reg, left_next;
    logic             pend_reg, pend_next;
    logic [AW-1:0]    dst_reg, dst_next;
    logic [AW-1:0]    idx_reg, idx_next;
    logic [AW-1:0]    ins_reg, ins_next;
    logic             up_reg, up_next;

    logic        strobe_reg, strobe_next;
    logic [1:0]  status_reg, status_next;
    logic [31:0] item_reg, item_next;
    logic [6:0]  cnt_out_reg, cnt_out_next;
    logic        last_reg, last_next;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [WIDTH-1:0] ram_wdata;
    logic [AW-1:0]    ram_raddr;
    logic [WIDTH-1:0] ram_rdata;

    logic [WIDTH-1:0] val_w;
    logic [WIDTH-1:0] key_w;
    logic [31:0]      rd32;
    logic             full;
    logic             empty;
    logic [8:0]       pos9;
    logic [8:0]       cnt9;
    logic             del_pos_ok;
    logic             ins_pos_ok;
    logic             hit;

    generate
        if (WIDTH == 32)
        begin : g_w_eq
            assign val_w = value;
            assign key_w = key;
            assign rd32  = ram_rdata;
        end
        else if (WIDTH > 32)
        begin : g_w_gt
            assign val_w = {{(WIDTH-32){1'b0}}, value};
            assign key_w = {{(WIDTH-32){1'b0}}, key};
            assign rd32  = ram_rdata[31:0];
        end
        else
        begin : g_w_lt
            assign val_w = value[WIDTH-1:0];
            assign key_w = key[WIDTH-1:0];
            assign rd32  = {{(32-WIDTH){1'b0}}, ram_rdata};
        end
    endgenerate

    assign full       = (count_reg == CW'(DEPTH));
    assign empty      = (count_reg == '0);
    assign pos9       = {1'b0, position};
    assign cnt9       = 9'(count_reg);
    assign del_pos_ok = (position != 8'd0) && (pos9 <= cnt9);
    assign ins_pos_ok = (position != 8'd0) && (pos9 <= cnt9 + 9'd1);
    assign hit        = (ram_rdata == key_reg);

    ols_ram #(
        .W (WIDTH),
        .D (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (cmd)
                        CMD_PUSH_BACK:      state_next = full ? ST_FRONT : ST_PUT;
                        CMD_PUSH_FRONT:     state_next = full ? ST_FRONT : ST_MOVE;
                        CMD_POP_FRONT:      state_next = empty ? ST_FRONT : ST_MOVE;
                        CMD_POP_BACK:       state_next = ST_FRONT;
                        CMD_DEL_KEY:        state_next = ST_SEARCH;
                        CMD_DEL_POS:        state_next = del_pos_ok ? ST_MOVE : ST_FRONT;
                        CMD_INS_POS:
                            state_next = (!full && ins_pos_ok) ? ST_MOVE : ST_FRONT;
                        CMD_INS_BEFORE_KEY: state_next = full ? ST_FRONT : ST_SEARCH;
                        CMD_DUMP:           state_next = empty ? ST_FRONT : ST_DUMP;
                        default:            state_next = ST_FRONT;
                    endcase
                end
            end
            ST_SEARCH:
            begin
                if (pend_reg && hit)
                begin
                    state_next = ST_MOVE;
                end
                else if (left_reg == '0)
                begin
                    state_next = ST_FRONT;
                end
            end
            ST_MOVE:
            begin
                if (!pend_reg && left_reg == '0)
                begin
                    state_next = up_reg ? ST_PUT : ST_FRONT;
                end
            end
            ST_PUT:        state_next = ST_FRONT;
            ST_FRONT:      state_next = ST_FRONT_WAIT;
            ST_FRONT_WAIT: state_next = ST_IDLE;
            ST_DUMP:
            begin
                if (pend_reg && left_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:       state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        count_next   = count_reg;
        val_next     = val_reg;
        key_next     = key_reg;
        stat_next    = stat_reg;
        ptr_next     = ptr_reg;
        left_next    = left_reg;
        pend_next    = pend_reg;
        dst_next     = dst_reg;
        idx_next     = idx_reg;
        ins_next     = ins_reg;
        up_next      = up_reg;
        strobe_next  = 1'b0;
        status_next  = status_reg;
        item_next    = item_reg;
        cnt_out_next = cnt_out_reg;
        last_next    = last_reg;
        ram_we       = 1'b0;
        ram_waddr    = dst_reg;
        ram_wdata    = ram_rdata;
        ram_raddr    = ptr_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    val_next  = val_w;
                    key_next  = key_w;
                    pend_next = 1'b0;
                    stat_next = STAT_DONE;
                    unique case (cmd)
                        CMD_PUSH_BACK:
                        begin
                            if (full)
                            begin
                                stat_next = STAT_FULL;
                            end
                            else
                            begin
                                ins_next = AW'(count_reg);
                                up_next  = 1'b1;
                            end
                        end
                        CMD_PUSH_FRONT:
                        begin
                            if (full)
                            begin
                                stat_next = STAT_FULL;
                            end
                            else
                            begin
                                ins_next  = '0;
                                left_next = count_reg;
                                ptr_next  = AW'(count_reg - 1'b1);
                                up_next   = 1'b1;
                            end
                        end
                        CMD_POP_FRONT:
                        begin
                            if (empty)
                            begin
                                stat_next = STAT_IGNORED;
                            end
                            else
                            begin
                                ptr_next   = AW'(1);
                                left_next  = CW'(count_reg - 1'b1);
                                up_next    = 1'b0;
                                count_next = CW'(count_reg - 1'b1);
                            end
                        end
                        CMD_POP_BACK:
                        begin
                            if (empty)
                            begin
                                stat_next = STAT_IGNORED;
                            end
                            else
                            begin
                                count_next = CW'(count_reg - 1'b1);
                            end
                        end
                        CMD_DEL_KEY:
                        begin
                            ptr_next  = '0;
                            left_next = count_reg;
                            up_next   = 1'b0;
                        end
                        CMD_DEL_POS:
                        begin
                            if (del_pos_ok)
                            begin
                                ptr_next   = AW'(position);
                                left_next  = CW'(count_reg - CW'(position));
                                up_next    = 1'b0;
                                count_next = CW'(count_reg - 1'b1);
                            end
                            else
                            begin
                                stat_next = STAT_IGNORED;
                            end
                        end
                        CMD_INS_POS:
                        begin
                            if (full)
                            begin
                                stat_next = STAT_FULL;
                            end
                            else if (ins_pos_ok)
                            begin
                                ins_next  = AW'(position - 8'd1);
                                left_next = CW'(count_reg + 1'b1 - CW'(position));
                                ptr_next  = AW'(count_reg - 1'b1);
                                up_next   = 1'b1;
                            end
                            else
                            begin
                                stat_next = STAT_IGNORED;
                            end
                        end
                        CMD_INS_BEFORE_KEY:
                        begin
                            if (full)
                            begin
                                stat_next = STAT_FULL;
                            end
                            else
                            begin
                                ptr_next  = '0;
                                left_next = count_reg;
                                up_next   = 1'b1;
                            end
                        end
                        CMD_DUMP:
                        begin
                            if (empty)
                            begin
                                stat_next = STAT_IGNORED;
                            end
                            else
                            begin
                                ptr_next  = '0;
                                left_next = count_reg;
                            end
                        end
                        default:
                        begin
                            stat_next = STAT_IGNORED;
                        end
                    endcase
                end
            end
            ST_SEARCH:
            begin
                if (pend_reg && hit)
                begin
                    pend_next = 1'b0;
                    if (up_reg)
                    begin
                        ins_next  = idx_reg;
                        left_next = CW'(count_reg - CW'(idx_reg));
                        ptr_next  = AW'(count_reg - 1'b1);
                    end
                    else
                    begin
                        ptr_next   = AW'(idx_reg + 1'b1);
                        left_next  = CW'(count_reg - CW'(idx_reg) - 1'b1);
                        count_next = CW'(count_reg - 1'b1);
                    end
                end
                else if (left_reg != '0)
                begin
                    pend_next = 1'b1;
                    idx_next  = ptr_reg;
                    ptr_next  = AW'(ptr_reg + 1'b1);
                    left_next = CW'(left_reg - 1'b1);
                end
                else
                begin
                    pend_next = 1'b0;
                    stat_next = STAT_IGNORED;
                end
            end
            ST_MOVE:
            begin
                if (pend_reg)
                begin
                    ram_we = 1'b1;
                end
                if (left_reg != '0)
                begin
                    pend_next = 1'b1;
                    dst_next  = up_reg ? AW'(ptr_reg + 1'b1) : AW'(ptr_reg - 1'b1);
                    ptr_next  = up_reg ? AW'(ptr_reg - 1'b1) : AW'(ptr_reg + 1'b1);
                    left_next = CW'(left_reg - 1'b1);
                end
                else
                begin
                    pend_next = 1'b0;
                end
            end
            ST_PUT:
            begin
                ram_we     = 1'b1;
                ram_waddr  = ins_reg;
                ram_wdata  = val_reg;
                count_next = CW'(count_reg + 1'b1);
            end
            ST_FRONT:
            begin
                ram_raddr = '0;
            end
            ST_FRONT_WAIT:
            begin
                strobe_next  = 1'b1;
                status_next  = stat_reg;
                item_next    = empty ? 32'd0 : rd32;
                cnt_out_next = 7'(count_reg);
                last_next    = 1'b1;
            end
            ST_DUMP:
            begin
                if (left_reg != '0)
                begin
                    pend_next = 1'b1;
                    ptr_next  = AW'(ptr_reg + 1'b1);
                    left_next = CW'(left_reg - 1'b1);
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg)
                begin
                    strobe_next  = 1'b1;
                    status_next  = STAT_DONE;
                    item_next    = rd32;
                    cnt_out_next = 7'(count_reg);
                    last_next    = (left_reg == '0);
                end
            end
            default:
            begin
                pend_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            pend_reg   <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            pend_reg   <= pend_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg     <= val_next;
        key_reg     <= key_next;
        stat_reg    <= stat_next;
        ptr_reg     <= ptr_next;
        left_reg    <= left_next;
        dst_reg     <= dst_next;
        idx_reg     <= idx_next;
        ins_reg     <= ins_next;
        up_reg      <= up_next;
        status_reg  <= status_next;
        item_reg    <= item_next;
        cnt_out_reg <= cnt_out_next;
        last_reg    <= last_next;
    end

    assign busy        = (state_reg != ST_IDLE);
    assign strobe      = strobe_reg;
    assign status      = status_reg;
    assign item_value  = item_reg;
    assign entry_count = cnt_out_reg;
    assign last        = last_reg;

endmodule

### rtl/ols_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// It depends on nothing else.
module ols_ram #(
    parameter int W = 32,
    parameter int D = 16
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [$clog2(D)-1:0] waddr,
    input  logic [W-1:0]         wdata,
    input  logic [$clog2(D)-1:0] raddr,
    output logic [W-1:0]         rdata
);

    logic [W-1:0] mem [D];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
